@@ hw/rtl/lpsc_pkg.sv @@
`default_nettype none

package lpsc_pkg;

  // Default geometry of the cache.
  localparam int SLOT_COUNT_DEF       = 6;
  localparam int PAGE_WORDS_DEF       = 256;
  localparam int PAGE_NUMBER_BITS_DEF = 16;

  // Fixed field widths of the stream interfaces.
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 24;
  localparam int SLOT_W    = 3;
  localparam int OFFSET_W  = 8;
  localparam int PAGE_W    = 16;
  localparam int STAMP_W   = 64;
  localparam int M_TDATA_W = 48;

  // Command codes carried on s_tuser.
  localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIRTY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // One result, declared from the highest bits down so that the slot
  // lands in the lowest bits of m_tdata.
  typedef struct packed {
    logic [1:0]          pad;
    logic [PAGE_W-1:0]   fill_page;
    logic                fill_valid;
    logic [PAGE_W-1:0]   writeback_page;
    logic                writeback_valid;
    logic                hit;
    logic [OFFSET_W-1:0] word_offset;
    logic [SLOT_W-1:0]   slot;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/lru_page_slot_controller.sv @@
`default_nettype none

// Tag, dirty and LRU controller for a fully associative write-back page cache.
// Each input transaction carries a command on s_tuser (access, mark dirty,
// flush) and an element index on s_tdata. The index is split into a page
// number and a word offset by a multiplication with the rounded-up reciprocal
// of the page size. The quotient is registered in a divide state, and the
// offset is the index minus the page base. A single comparator then walks
// the slots one per cycle. It looks for the page and tracks the least
// recently stamped slot at the same time. A commit state then applies the
// state update and loads the result, waiting until the output register is
// free. A flush walks the slots with the same pointer and produces one
// result per slot, each as the output register frees. An unknown command is
// accepted and dropped with no result, and the block is ready again on the
// next cycle. A finished result sits in an output register, so a new
// transaction can be accepted while the previous result still waits for
// m_tready. There is no clearing pass after reset. The valid, dirty and
// stamp state resets at once, and page tags are only read behind a
// valid flag.
module lru_page_slot_controller #(
  parameter int SLOT_COUNT       = lpsc_pkg::SLOT_COUNT_DEF,
  parameter int PAGE_WORDS       = lpsc_pkg::PAGE_WORDS_DEF,
  parameter int PAGE_NUMBER_BITS = lpsc_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Request stream.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [lpsc_pkg::INDEX_W-1:0]   s_tdata,   // item_index[23:0]
  input  wire logic [lpsc_pkg::CMD_W-1:0]     s_tuser,   // cmd[1:0]
  // Result stream.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // slot[2:0], word_offset[10:3], hit[11], writeback_valid[12],
  // writeback_page[28:13], fill_valid[29], fill_page[45:30], zero[47:46]
  output logic [lpsc_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tlast
);

  import lpsc_pkg::*;

  localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
  // A reciprocal rounded up with this many fraction bits gives the exact
  // quotient for every index of INDEX_W bits.
  localparam int PAGE_SHIFT  = $clog2(PAGE_WORDS);
  localparam int RECIP_SHIFT = INDEX_W + PAGE_SHIFT;
  localparam int PROD_W      = 2 * INDEX_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + 64'(PAGE_WORDS) - 64'd1) / 64'(PAGE_WORDS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  // Cache state.
  logic [SLOT_COUNT-1:0]       slot_valid;
  logic [SLOT_COUNT-1:0]       slot_dirty;
  logic [PAGE_NUMBER_BITS-1:0] slot_page [SLOT_COUNT];
  logic [STAMP_W-1:0]          slot_stamp [SLOT_COUNT];
  logic [STAMP_W-1:0]          stamp_counter;

  // Sequencer and working registers.
  logic [2:0]            state;
  logic [CMD_W-1:0]      cmd;
  logic [INDEX_W-1:0]    idx;
  logic [INDEX_W-1:0]    quo;
  logic [SLOT_IDX_W-1:0] ptr;
  logic                  found;
  logic [SLOT_IDX_W-1:0] hit_slot;
  logic [SLOT_IDX_W-1:0] best_slot;
  logic [STAMP_W-1:0]    best_stamp;

  // Output register.
  result_t res;
  logic    res_last;
  logic    out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = res;
  assign m_tlast  = res_last;

  logic out_free;
  assign out_free = !out_valid || m_tready;

  // Page split: quotient by reciprocal multiplication, offset by subtraction.
  logic [PROD_W-1:0]  recip_prod;
  logic [INDEX_W-1:0] page_base;
  logic [INDEX_W-1:0] rem;
  assign recip_prod = PROD_W'(idx) * PROD_W'(RECIP);
  assign page_base  = quo * INDEX_W'(PAGE_WORDS);
  assign rem        = idx - page_base;

  logic [PAGE_NUMBER_BITS-1:0] tgt_page;
  logic [OFFSET_W-1:0]         tgt_offset;
  assign tgt_page   = PAGE_NUMBER_BITS'(quo);
  assign tgt_offset = OFFSET_W'(rem);

  // Shared slot comparator: page match and stamp minimum at the pointer.
  logic                  scan_match;
  logic                  scan_better;
  logic                  found_next;
  logic [SLOT_IDX_W-1:0] hit_slot_next;
  logic [SLOT_IDX_W-1:0] best_slot_next;
  logic [STAMP_W-1:0]    best_stamp_next;
  logic                  ptr_at_end;

  always_comb begin
    scan_match      = slot_valid[ptr] && (slot_page[ptr] == tgt_page);
    scan_better     = (ptr == '0) || (slot_stamp[ptr] < best_stamp);
    found_next      = found || scan_match;
    hit_slot_next   = (!found && scan_match) ? ptr : hit_slot;
    best_slot_next  = scan_better ? ptr : best_slot;
    best_stamp_next = scan_better ? slot_stamp[ptr] : best_stamp;
  end

  assign ptr_at_end = (ptr == SLOT_IDX_W'(SLOT_COUNT - 1));

  // Slot contents at the pointer, used by commit and flush.
  logic rd_wb;
  assign rd_wb = slot_valid[ptr] && slot_dirty[ptr];

  logic commit_go;
  logic flush_go;
  logic page_we;
  assign commit_go = (state == S_COMMIT) && out_free;
  assign flush_go  = (state == S_FLUSH) && out_free;
  assign page_we   = commit_go && (cmd == CMD_ACCESS) && !found;

  // Result assembled for the current commit or flush step.
  result_t res_next;
  always_comb begin
    res_next = '0;
    if (state == S_FLUSH) begin
      res_next.slot            = SLOT_W'(ptr);
      res_next.writeback_valid = rd_wb;
      res_next.writeback_page  = rd_wb ? PAGE_W'(slot_page[ptr]) : '0;
    end else begin
      res_next.word_offset = tgt_offset;
      if (found) begin
        res_next.slot = SLOT_W'(ptr);
        res_next.hit  = 1'b1;
      end else if (cmd == CMD_ACCESS) begin
        // Miss: report the victim, its write-back if dirty, and the fill.
        res_next.slot            = SLOT_W'(ptr);
        res_next.writeback_valid = rd_wb;
        res_next.writeback_page  = rd_wb ? PAGE_W'(slot_page[ptr]) : '0;
        res_next.fill_valid      = 1'b1;
        res_next.fill_page       = PAGE_W'(tgt_page);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      slot_valid    <= '0;
      slot_dirty    <= '0;
      stamp_counter <= STAMP_W'(1);
      ptr           <= '0;
      found         <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_stamp[i] <= '0;
      end
    end else begin
      // A new result loads in the same cycle the old one leaves.
      if (commit_go || flush_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tuser;
            idx   <= s_tdata;
            ptr   <= '0;
            found <= 1'b0;
            if (s_tuser == CMD_FLUSH) begin
              state <= S_FLUSH;
            end else if (s_tuser == CMD_ACCESS || s_tuser == CMD_DIRTY) begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo   <= INDEX_W'(recip_prod >> RECIP_SHIFT);
          state <= S_SCAN;
        end
        S_SCAN: begin
          found      <= found_next;
          hit_slot   <= hit_slot_next;
          best_slot  <= best_slot_next;
          best_stamp <= best_stamp_next;
          if (ptr_at_end) begin
            // Park the pointer on the slot the commit will touch.
            if (found_next) begin
              ptr <= hit_slot_next;
            end else if (cmd == CMD_ACCESS) begin
              ptr <= best_slot_next;
            end else begin
              ptr <= '0;
            end
            state <= S_COMMIT;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            res      <= res_next;
            res_last <= 1'b1;
            state    <= S_IDLE;
            if (cmd == CMD_ACCESS) begin
              slot_stamp[ptr] <= stamp_counter;
              stamp_counter   <= stamp_counter + 1'b1;
              if (!found) begin
                slot_valid[ptr] <= 1'b1;
                slot_dirty[ptr] <= 1'b0;
              end
            end else if (found) begin
              slot_dirty[ptr] <= 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            res             <= res_next;
            res_last        <= ptr_at_end;
            slot_dirty[ptr] <= 1'b0;
            if (ptr_at_end) begin
              state <= S_IDLE;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Page tags carry no reset; they are only read behind a valid flag.
  always_ff @(posedge clk) begin
    if (page_we) begin
      slot_page[ptr] <= tgt_page;
    end
  end

  // The slot pointer never leaves the slot range.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= SLOT_IDX_W'(SLOT_COUNT - 1))
    else $error("slot pointer out of range");

  // A hit never asks for a write-back or a fill.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.hit |-> !res.writeback_valid && !res.fill_valid)
    else $error("hit result carries write-back or fill");

  // A flush starts its walk at slot zero.
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_FLUSH) |=> (state == S_FLUSH) && (ptr == '0))
    else $error("flush did not start at slot zero");

  // Resident slots are never dropped once filled.
  a_valid_grow: assert property (@(posedge clk) disable iff (rst)
    !rst |=> $countones(slot_valid) >= $past($countones(slot_valid)))
    else $error("valid slot count decreased");

endmodule

`default_nettype wire
